// ===== rtl/core/ftrm_pkg.sv =====
// Shared types and constants for the fan tachometer speed meter.
`timescale 1ns / 1ps
package ftrm_pkg;

  localparam int AVG_DEPTH = 8;
  localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W     = $clog2(AVG_DEPTH + 1);

  localparam int MODE_W    = 2;
  localparam int CAP_W     = 16;
  localparam int TIME_W    = 32;
  localparam int RPM_W     = 27;
  localparam int PPR_W     = 3;
  localparam int TICK_W    = 17;
  localparam int WARM_W    = 4;
  localparam int SUM_W     = CAP_W + $clog2(AVG_DEPTH);
  localparam int K_W       = 13;
  localparam int NUM_W     = TICK_W + K_W;
  localparam int DEN_W     = PPR_W + CAP_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [K_W-1:0]    RPM_K     = K_W'(6000);
  localparam logic [RPM_W-1:0]  SPEED_MAX = {RPM_W{1'b1}};

  localparam logic [PPR_W-1:0]  PPR_RST    = PPR_W'(2);
  localparam logic [TICK_W-1:0] TICK_RST   = TICK_W'(10000);
  localparam logic [CAP_W-1:0]  TMO_RST    = CAP_W'(700);
  localparam logic [CAP_W-1:0]  MINP_RST   = CAP_W'(5);
  localparam logic [CAP_W-1:0]  MAXP_RST   = CAP_W'(65530);
  localparam logic [WARM_W-1:0] WARM_RST   = WARM_W'(3);

  typedef enum logic [MODE_W-1:0] {
    MODE_EDGE    = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_READ    = 2'd2
  } mode_e_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PPR    = 3'd0,
    REG_TICK   = 3'd1,
    REG_TMO    = 3'd2,
    REG_MINP   = 3'd3,
    REG_MAXP   = 3'd4,
    REG_WARMUP = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SUM,
    S_DIV1,
    S_MUL,
    S_START2,
    S_DIV2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm_centi;
    logic             updated;
    logic             timed_out;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/core/ftrm_if.sv =====
// Request channel interfaces: tach/command input and speed result output.
`timescale 1ns / 1ps
interface ftrm_in_if;
  logic                        valid;
  logic                        ready;
  logic [ftrm_pkg::MODE_W-1:0] mode;
  logic [ftrm_pkg::CAP_W-1:0]  capture_value;
  logic [ftrm_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, mode, capture_value, now_ms, input ready);
  modport sink   (input valid, mode, capture_value, now_ms, output ready);
endinterface

interface ftrm_out_if;
  logic                       valid;
  logic                       ready;
  logic [ftrm_pkg::RPM_W-1:0] rpm_centi;
  logic                       updated;
  logic                       timed_out;

  modport source (output valid, rpm_centi, updated, timed_out, input ready);
  modport sink   (input valid, rpm_centi, updated, timed_out, output ready);
endinterface

// ===== rtl/core/ftrm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ftrm_div import ftrm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W:0]    rem_sh;
  logic              q_bit;

  always_comb begin
    rem_sh   = {rem_r, quo_r[NUM_W-1]};
    q_bit    = (rem_sh >= {1'b0, den_r});
    iter_nxt = iter_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      iter_nxt = ITER_W'(NUM_W);
      busy_nxt = 1'b1;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[NUM_W-2:0], q_bit};
      rem_nxt  = q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      iter_nxt = iter_r - 1'b1;
      if (iter_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/fan_tach_rpm_meter_top.sv =====
// Top level of the fan tachometer speed meter.
`timescale 1ns / 1ps
// Fan speed meter from tach edge timestamps on a 16-bit capture timer.
// in_ch carries one request per item: mode (tach edge, restart, read),
// capture_value and now_ms. out_ch returns exactly one result per request:
// rpm_centi, updated and timed_out. cfg_we/cfg_addr/cfg_wdata write the six
// setup registers (pulses per rev, tick rate, timeout, period window,
// warmup count); write only while no request is in flight.
// Restart, read and priming edges go from idle straight to S_OUT; rejected
// edges pass the check state first. An accepted period takes the check
// state, a sweep over the AVG_DEPTH-entry period ring, then two passes
// through the shared bit-serial divider (ring mean, then speed
// quotient). One request is processed at a time; in_ch.ready is high
// whenever the engine is idle, also while a result waits on out_ch.
// Reset (rst_n low, synchronous) loads the register defaults and empties
// the measurement state. When out_ch is stalled the finished result holds
// in the output register and the next result waits in the engine until
// the output register drains.
module fan_tach_rpm_meter_top import ftrm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ftrm_in_if.sink               in_ch,
  ftrm_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [PPR_W-1:0]  ppr_r;
  logic [TICK_W-1:0] tick_r;
  logic [CAP_W-1:0]  tmo_r;
  logic [CAP_W-1:0]  minp_r;
  logic [CAP_W-1:0]  maxp_r;
  logic [WARM_W-1:0] warm_cfg_r;

  logic [CAP_W-1:0]  last_cap_r;
  logic              primed_r;
  logic [CAP_W-1:0]  ring_r [AVG_DEPTH];
  logic [IDX_W-1:0]  ring_idx_r;
  logic [WARM_W-1:0] warm_left_r;
  logic [RPM_W-1:0]  speed_r;
  logic [TIME_W-1:0] last_upd_r;
  logic              have_r;

  state_t            state_r, state_nxt;
  logic [CAP_W-1:0]  period_r;
  logic [TIME_W-1:0] pend_now_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  sweep_r;
  logic [CAP_W-1:0]  mean_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  result_t           res_r;
  result_t           out_r;
  logic              out_valid_r;

  logic              in_fire;
  logic              out_free;
  logic              period_ok;
  logic              sweep_last;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [PPR_W-1:0]  ppr_eff;
  logic [TIME_W-1:0] age;
  logic              stale;
  div_req_t          div_req;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [RPM_W-1:0]  speed_sat;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign period_ok  = (period_r != '0) && (period_r >= minp_r) && (period_r <= maxp_r);
  assign sweep_last = (sweep_r == IDX_W'(AVG_DEPTH - 1));
  assign sum_nxt    = sum_r + SUM_W'(ring_r[sweep_r]);
  assign cnt_nxt    = cnt_r + CNT_W'(ring_r[sweep_r] != '0);
  assign ppr_eff    = (ppr_r == '0) ? PPR_W'(1) : ppr_r;
  assign age        = in_ch.now_ms - last_upd_r;
  assign stale      = !have_r || (age > TIME_W'(tmo_r));
  assign speed_sat  = (div_quo[NUM_W-1:RPM_W] != '0) ? SPEED_MAX : div_quo[RPM_W-1:0];

  ftrm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = NUM_W'(sum_nxt);
    div_req.divisor  = DEN_W'(cnt_nxt);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_ch.mode == MODE_EDGE) && primed_r) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_CHECK: begin
        state_nxt = (period_ok && (warm_left_r == '0)) ? S_SUM : S_OUT;
      end
      S_SUM: begin
        if (sweep_last) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_START2;
      end
      S_START2: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_r;
        div_req.divisor  = den_r;
        state_nxt        = S_DIV2;
      end
      S_DIV2: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // setup registers and measurement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r       <= PPR_RST;
      tick_r      <= TICK_RST;
      tmo_r       <= TMO_RST;
      minp_r      <= MINP_RST;
      maxp_r      <= MAXP_RST;
      warm_cfg_r  <= WARM_RST;
      last_cap_r  <= '0;
      primed_r    <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      ring_idx_r  <= '0;
      warm_left_r <= WARM_RST;
      speed_r     <= '0;
      last_upd_r  <= '0;
      have_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PPR:    ppr_r      <= cfg_wdata[PPR_W-1:0];
          REG_TICK:   tick_r     <= cfg_wdata[TICK_W-1:0];
          REG_TMO:    tmo_r      <= cfg_wdata[CAP_W-1:0];
          REG_MINP:   minp_r     <= cfg_wdata[CAP_W-1:0];
          REG_MAXP:   maxp_r     <= cfg_wdata[CAP_W-1:0];
          REG_WARMUP: warm_cfg_r <= cfg_wdata[WARM_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_ch.mode)
              MODE_EDGE: begin
                primed_r   <= 1'b1;
                last_cap_r <= in_ch.capture_value;
              end
              MODE_RESTART: begin
                last_cap_r  <= '0;
                primed_r    <= 1'b0;
                for (int i = 0; i < AVG_DEPTH; i++) begin
                  ring_r[i] <= '0;
                end
                ring_idx_r  <= '0;
                warm_left_r <= warm_cfg_r;
                speed_r     <= '0;
                last_upd_r  <= '0;
                have_r      <= 1'b0;
              end
              MODE_READ: begin
                if (stale) begin
                  speed_r <= '0;
                  have_r  <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          if (period_ok) begin
            if (warm_left_r != '0) begin
              warm_left_r <= warm_left_r - 1'b1;
            end else begin
              ring_r[ring_idx_r] <= period_r;
              ring_idx_r <= (ring_idx_r == IDX_W'(AVG_DEPTH - 1)) ? '0 : ring_idx_r + 1'b1;
            end
          end
        end
        S_DIV2: begin
          if (div_done) begin
            speed_r    <= speed_sat;
            last_upd_r <= pend_now_r;
            have_r     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and pending result
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pend_now_r <= in_ch.now_ms;
          period_r   <= in_ch.capture_value - last_cap_r;
          res_r      <= '{rpm_centi: ((in_ch.mode == MODE_EDGE) ||
                                      ((in_ch.mode == MODE_READ) && !stale)) ? speed_r : '0,
                          updated:   1'b0,
                          timed_out: (in_ch.mode == MODE_READ) && stale};
        end
      end
      S_CHECK: begin
        sum_r   <= '0;
        cnt_r   <= '0;
        sweep_r <= '0;
      end
      S_SUM: begin
        sum_r   <= sum_nxt;
        cnt_r   <= cnt_nxt;
        sweep_r <= sweep_r + 1'b1;
      end
      S_DIV1: begin
        if (div_done) begin
          mean_r <= div_quo[CAP_W-1:0];
        end
      end
      S_MUL: begin
        num_r <= NUM_W'(tick_r * RPM_K);
        den_r <= DEN_W'(ppr_eff * mean_r);
      end
      S_DIV2: begin
        if (div_done) begin
          res_r <= '{rpm_centi: speed_sat, updated: 1'b1, timed_out: 1'b0};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if ((state_r == S_OUT) && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.rpm_centi = out_r.rpm_centi;
  assign out_ch.updated   = out_r.updated;
  assign out_ch.timed_out = out_r.timed_out;

endmodule
